FILE: hdl/gn2_pkg.sv
// Shared constants and types for the 2-D gradient noise block.
`timescale 1ns / 1ps
package gn2_pkg;

    localparam int DEF_MAX_GRID_WIDTH  = 64;
    localparam int DEF_MAX_GRID_HEIGHT = 64;
    localparam int DEF_MAX_SCALE       = 64;

    localparam int CFG_W      = 7;    // width of each configuration register
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 16;

    // pixel / (scale) with 16 fraction bits, 4 quotient bits per stage
    localparam int PIX_W      = 12;
    localparam int FRAC_W     = 16;
    localparam int QUO_W      = PIX_W + FRAC_W;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = QUO_W / DIV_BITS;

    localparam int MATH_STAGES = 9;
    localparam int PIPE_STAGES = DIV_STAGES + MATH_STAGES;

    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_SCALE       = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic       oor;
        logic [15:0] noise;
    } result_t;

endpackage

FILE: hdl/gradient_noise_2d.sv
// Top level of the 2-D gradient noise block: config, sideband pipe, result queue.
//
//  channel  | dir | content
//  ---------+-----+---------------------------------------------------------
//  s_axis   | in  | write gradient or evaluate pixel request, op in tuser
//  m_axis   | out | noise value, out-of-range flag in tuser
//  apb      | in  | grid_width @0x0, grid_height @0x4, scale_factor @0x8
//
//  One request per cycle while s_tready is high. An evaluate request passes the
//  7 divider stages, the gradient memory read alongside the first of 9
//  arithmetic stages, then the result queue write.
//  Results queue in a 32-entry buffer; s_tready drops only when 32 results
//  are in flight or waiting. The gradient memories are not cleared by reset;
//  rst_n clears the registers, pipeline valids and queue pointers.
`timescale 1ns / 1ps
module gradient_noise_2d
#(
    parameter int MAX_GRID_WIDTH  = gn2_pkg::DEF_MAX_GRID_WIDTH,
    parameter int MAX_GRID_HEIGHT = gn2_pkg::DEF_MAX_GRID_HEIGHT,
    parameter int MAX_SCALE       = gn2_pkg::DEF_MAX_SCALE
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // grid_col[5:0] grid_row[11:6] grad_x[27:12] grad_y[43:28]
    // pixel_col[55:44] pixel_row[67:56], zero pad
    input  logic [gn2_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]                     s_tuser,   // operation[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gn2_pkg::M_TDATA_W-1:0]  m_tdata,   // noise_value[15:0]
    output logic [0:0]                     m_tuser,   // out_of_range[0]
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gn2_pkg::PADDR_W-1:0]    paddr,
    input  logic [gn2_pkg::PDATA_W-1:0]    pwdata,
    output logic [gn2_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import gn2_pkg::*;

    localparam int CW = $clog2(MAX_GRID_WIDTH);
    localparam int RW = $clog2(MAX_GRID_HEIGHT);

    logic [CFG_W-1:0] grid_width_reg, grid_height_reg, scale_reg;

    logic [5:0]       in_col, in_row;
    logic [15:0]      in_gx, in_gy;
    logic [PIX_W-1:0] in_px, in_py;
    logic             accept, in_eval, wr_ok, out_take, cfg_wr;

    logic [8:0]       gw9, gh9, sf9;
    logic [CFG_W-1:0] gw_c, gh_c, sf_c;
    logic [13:0]      lim_x, lim_y;
    logic             in_oor;

    logic             sb_eval_reg [PIPE_STAGES];
    logic             sb_oor_reg  [PIPE_STAGES];
    logic             wr_v_reg    [DIV_STAGES];
    logic [CW-1:0]    wr_col_reg  [DIV_STAGES];
    logic [RW-1:0]    wr_row_reg  [DIV_STAGES];
    logic [31:0]      wr_data_reg [DIV_STAGES];

    logic [QUO_W-1:0] quo_x, quo_y;
    logic [31:0]      c00, c10, c01, c11;
    logic [15:0]      noise;

    result_t            fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   fifo_cnt_reg, fifo_cnt_next;
    logic [FIFO_AW:0]   credit_reg, credit_next;
    logic               push;
    result_t            push_data, head;

    assign in_col = s_tdata[5:0];
    assign in_row = s_tdata[11:6];
    assign in_gx  = s_tdata[27:12];
    assign in_gy  = s_tdata[43:28];
    assign in_px  = s_tdata[55:44];
    assign in_py  = s_tdata[67:56];

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= CFG_W'(2);
            grid_height_reg <= CFG_W'(2);
            scale_reg       <= CFG_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[CFG_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[CFG_W-1:0];
                REG_SCALE:       scale_reg       <= pwdata[CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = PDATA_W'(grid_height_reg);
            REG_SCALE:       prdata = PDATA_W'(scale_reg);
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        gw9 = {2'b0, grid_width_reg};
        gh9 = {2'b0, grid_height_reg};
        sf9 = {2'b0, scale_reg};
        if (gw9 < 9'd2)
            gw9 = 9'd2;
        else if (gw9 > 9'(MAX_GRID_WIDTH))
            gw9 = 9'(MAX_GRID_WIDTH);
        if (gh9 < 9'd2)
            gh9 = 9'd2;
        else if (gh9 > 9'(MAX_GRID_HEIGHT))
            gh9 = 9'(MAX_GRID_HEIGHT);
        if (sf9 < 9'd1)
            sf9 = 9'd1;
        else if (sf9 > 9'(MAX_SCALE))
            sf9 = 9'(MAX_SCALE);
        gw_c  = gw9[CFG_W-1:0];
        gh_c  = gh9[CFG_W-1:0];
        sf_c  = sf9[CFG_W-1:0];
        lim_x = {7'b0, gw_c - CFG_W'(1)} * {7'b0, sf_c};
        lim_y = {7'b0, gh_c - CFG_W'(1)} * {7'b0, sf_c};
        in_oor = ({2'b0, in_px} >= lim_x) || ({2'b0, in_py} >= lim_y);
    end

    // ---------------- request side ----------------
    assign accept   = s_tvalid && s_tready;
    assign in_eval  = accept && (s_tuser[0] == OP_EVAL);
    assign wr_ok    = accept && (s_tuser[0] == OP_WRITE)
                      && ({3'b0, in_col} < 9'(MAX_GRID_WIDTH))
                      && ({3'b0, in_row} < 9'(MAX_GRID_HEIGHT));
    assign out_take = m_tvalid && m_tready;

    // credit covers every evaluate request in the pipe plus the queue
    assign s_tready    = credit_reg < (FIFO_AW+1)'(FIFO_DEPTH);
    assign credit_next = credit_reg + (FIFO_AW+1)'(in_eval) - (FIFO_AW+1)'(out_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            for (int s = 0; s < PIPE_STAGES; s++)
            begin
                sb_eval_reg[s] <= 1'b0;
            end
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                wr_v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            credit_reg <= credit_next;
            for (int s = 0; s < PIPE_STAGES; s++)
            begin
                sb_eval_reg[s] <= (s == 0) ? in_eval : sb_eval_reg[s-1];
            end
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                wr_v_reg[s] <= (s == 0) ? wr_ok : wr_v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < PIPE_STAGES; s++)
        begin
            sb_oor_reg[s] <= (s == 0) ? in_oor : sb_oor_reg[s-1];
        end
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                wr_col_reg[s]  <= CW'(in_col);
                wr_row_reg[s]  <= RW'(in_row);
                wr_data_reg[s] <= {in_gy, in_gx};
            end
            else
            begin
                wr_col_reg[s]  <= wr_col_reg[s-1];
                wr_row_reg[s]  <= wr_row_reg[s-1];
                wr_data_reg[s] <= wr_data_reg[s-1];
            end
        end
    end

    // ---------------- datapath ----------------
    gn2_div u_div_x
    (
        .clk (clk),
        .num (in_px),
        .den (sf_c),
        .quo (quo_x)
    );

    gn2_div u_div_y
    (
        .clk (clk),
        .num (in_py),
        .den (sf_c),
        .quo (quo_y)
    );

    // writes land in the same stage that issues reads, so order is kept
    gn2_store
    #(
        .MAXW (MAX_GRID_WIDTH),
        .MAXH (MAX_GRID_HEIGHT)
    )
    u_store
    (
        .clk     (clk),
        .wr_en   (wr_v_reg[DIV_STAGES-1]),
        .wr_col  (wr_col_reg[DIV_STAGES-1]),
        .wr_row  (wr_row_reg[DIV_STAGES-1]),
        .wr_data (wr_data_reg[DIV_STAGES-1]),
        .rd_col  (CW'(quo_x[QUO_W-1:FRAC_W])),
        .rd_row  (RW'(quo_y[QUO_W-1:FRAC_W])),
        .c00     (c00),
        .c10     (c10),
        .c01     (c01),
        .c11     (c11)
    );

    gn2_math u_math
    (
        .clk   (clk),
        .fx    (quo_x[FRAC_W-1:0]),
        .fy    (quo_y[FRAC_W-1:0]),
        .c00   (c00),
        .c10   (c10),
        .c01   (c01),
        .c11   (c11),
        .noise (noise)
    );

    // ---------------- result queue ----------------
    assign push            = sb_eval_reg[PIPE_STAGES-1];
    assign push_data.oor   = sb_oor_reg[PIPE_STAGES-1];
    assign push_data.noise = sb_oor_reg[PIPE_STAGES-1] ? 16'h0000 : noise;
    assign fifo_cnt_next   = fifo_cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(out_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (out_take)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = fifo_mem_reg[rd_ptr_reg];
    assign m_tvalid   = fifo_cnt_reg != '0;
    assign m_tdata    = head.noise;
    assign m_tuser[0] = head.oor;

endmodule

FILE: hdl/gn2_div.sv
// Pipelined restoring divider: {num, 16'b0} / den, four quotient bits per stage.
`timescale 1ns / 1ps
module gn2_div
(
    input  logic                        clk,
    input  logic [gn2_pkg::PIX_W-1:0]   num,
    input  logic [gn2_pkg::CFG_W-1:0]   den,
    output logic [gn2_pkg::QUO_W-1:0]   quo
);
    import gn2_pkg::*;

    logic [CFG_W-1:0] rem_reg  [DIV_STAGES];
    logic [QUO_W-1:0] dvd_reg  [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg  [DIV_STAGES];
    logic [CFG_W-1:0] den_reg  [DIV_STAGES];

    logic [CFG_W-1:0] rem_in   [DIV_STAGES];
    logic [QUO_W-1:0] dvd_in   [DIV_STAGES];
    logic [QUO_W-1:0] quo_in   [DIV_STAGES];
    logic [CFG_W-1:0] den_in   [DIV_STAGES];
    logic [CFG_W-1:0] rem_next [DIV_STAGES];
    logic [DIV_BITS-1:0] q_next [DIV_STAGES];

    function automatic logic [CFG_W+DIV_BITS-1:0] step(input logic [CFG_W-1:0] r_in,
                                                       input logic [DIV_BITS-1:0] bits,
                                                       input logic [CFG_W-1:0] d);
        logic [CFG_W-1:0]    r;
        logic [CFG_W:0]      t;
        logic [DIV_BITS-1:0] q;
        r = r_in;
        q = '0;
        for (int i = DIV_BITS - 1; i >= 0; i--)
        begin
            t = {r, bits[i]};
            if (t >= {1'b0, d})
            begin
                r    = CFG_W'(t - {1'b0, d});
                q[i] = 1'b1;
            end
            else
            begin
                r = t[CFG_W-1:0];
            end
        end
        return {r, q};
    endfunction

    always_comb
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                rem_in[s] = '0;
                dvd_in[s] = {num, {FRAC_W{1'b0}}};
                quo_in[s] = '0;
                den_in[s] = den;
            end
            else
            begin
                rem_in[s] = rem_reg[s-1];
                dvd_in[s] = dvd_reg[s-1];
                quo_in[s] = quo_reg[s-1];
                den_in[s] = den_reg[s-1];
            end
            {rem_next[s], q_next[s]} = step(rem_in[s], dvd_in[s][QUO_W-1 -: DIV_BITS],
                                            den_in[s]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem_reg[s] <= rem_next[s];
            dvd_reg[s] <= {dvd_in[s][QUO_W-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
            quo_reg[s] <= {quo_in[s][QUO_W-DIV_BITS-1:0], q_next[s]};
            den_reg[s] <= den_in[s];
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

FILE: hdl/gn2_store.sv
// Gradient store: two row-parity banks, each with one write and two read ports.
`timescale 1ns / 1ps
module gn2_store
#(
    parameter int MAXW = gn2_pkg::DEF_MAX_GRID_WIDTH,
    parameter int MAXH = gn2_pkg::DEF_MAX_GRID_HEIGHT
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(MAXW)-1:0]  wr_col,
    input  logic [$clog2(MAXH)-1:0]  wr_row,
    input  logic [31:0]              wr_data,
    input  logic [$clog2(MAXW)-1:0]  rd_col,
    input  logic [$clog2(MAXH)-1:0]  rd_row,
    output logic [31:0]              c00,
    output logic [31:0]              c10,
    output logic [31:0]              c01,
    output logic [31:0]              c11
);
    localparam int CW  = $clog2(MAXW);
    localparam int RW  = $clog2(MAXH);
    localparam int BD  = ((MAXH + 1) / 2) * MAXW;
    localparam int BAW = $clog2(BD);

    logic [31:0] mem_even_reg [BD];
    logic [31:0] mem_odd_reg  [BD];
    logic [31:0] even_a_reg, even_b_reg, odd_a_reg, odd_b_reg;
    logic        odd_base_reg;

    logic [RW-1:0]  row_b, even_row, odd_row;
    logic [CW-1:0]  col_b;
    logic [BAW-1:0] wr_addr, even_a, even_b, odd_a, odd_b;

    function automatic logic [BAW-1:0] bank_addr(input logic [RW-1:0] row,
                                                 input logic [CW-1:0] col);
        logic [15:0] a;
        a = 16'(row >> 1) * 16'(MAXW) + 16'(col);
        return BAW'(a);
    endfunction

    // y0 and y0+1 always fall into different banks
    always_comb
    begin
        row_b    = rd_row + RW'(1);
        col_b    = rd_col + CW'(1);
        even_row = rd_row[0] ? row_b : rd_row;
        odd_row  = rd_row[0] ? rd_row : row_b;
        even_a   = bank_addr(even_row, rd_col);
        even_b   = bank_addr(even_row, col_b);
        odd_a    = bank_addr(odd_row, rd_col);
        odd_b    = bank_addr(odd_row, col_b);
        wr_addr  = bank_addr(wr_row, wr_col);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_row[0])
        begin
            mem_even_reg[wr_addr] <= wr_data;
        end
        if (wr_en && wr_row[0])
        begin
            mem_odd_reg[wr_addr] <= wr_data;
        end
        even_a_reg   <= mem_even_reg[even_a];
        even_b_reg   <= mem_even_reg[even_b];
        odd_a_reg    <= mem_odd_reg[odd_a];
        odd_b_reg    <= mem_odd_reg[odd_b];
        odd_base_reg <= rd_row[0];
    end

    assign c00 = odd_base_reg ? odd_a_reg  : even_a_reg;
    assign c10 = odd_base_reg ? odd_b_reg  : even_b_reg;
    assign c01 = odd_base_reg ? even_a_reg : odd_a_reg;
    assign c11 = odd_base_reg ? even_b_reg : odd_b_reg;

endmodule

FILE: hdl/gn2_math.sv
// Smoothstep weights, corner dot products and the two blends, nine stages.
`timescale 1ns / 1ps
module gn2_math
(
    input  logic        clk,
    input  logic [15:0] fx,
    input  logic [15:0] fy,
    input  logic [31:0] c00,
    input  logic [31:0] c10,
    input  logic [31:0] c01,
    input  logic [31:0] c11,
    output logic [15:0] noise
);
    import gn2_pkg::*;

    logic [15:0] f2x_reg, f2y_reg, fx1_reg, fy1_reg;
    logic [16:0] sx_reg, sy_reg, sx2_reg, sy2_reg, sx3_reg, sy3_reg, sy4_reg, sy5_reg;
    logic [16:0] sy6_reg;
    logic signed [32:0] p00x_reg, p00y_reg, p10x_reg, p10y_reg;
    logic signed [32:0] p01x_reg, p01y_reg, p11x_reg, p11y_reg;
    logic signed [33:0] n00_reg, n10_reg, n01_reg, n11_reg, n00_4_reg, n01_4_reg;
    logic signed [33:0] n00_5_reg, n01_5_reg;
    logic signed [34:0] dt_reg, db_reg;
    logic signed [52:0] pt_reg, pb_reg;
    logic signed [35:0] top_reg, bot_reg, d_reg, top7_reg, top8_reg;
    logic signed [53:0] p_reg;
    logic [15:0]        noise_reg;

    logic signed [16:0] dx0, dx1, dy0, dy1;
    logic [17:0]        tx, ty;
    logic [33:0]        wx, wy;
    logic signed [35:0] v;
    logic signed [19:0] vq;

    always_comb
    begin
        // offset from the far corner is f - 1.0, which is {1, f} in 17 bits
        dx0 = $signed({1'b0, fx1_reg});
        dx1 = $signed({1'b1, fx1_reg});
        dy0 = $signed({1'b0, fy1_reg});
        dy1 = $signed({1'b1, fy1_reg});
        tx  = 18'd196608 - {1'b0, fx1_reg, 1'b0};
        ty  = 18'd196608 - {1'b0, fy1_reg, 1'b0};
        wx  = {18'b0, f2x_reg} * {16'b0, tx};
        wy  = {18'b0, f2y_reg} * {16'b0, ty};
        v   = top8_reg + 36'(p_reg >>> 16);
        vq  = 20'(v >>> 16);
    end

    always_ff @(posedge clk)
    begin
        // stage 1
        f2x_reg <= 16'(({16'b0, fx} * {16'b0, fx}) >> 16);
        f2y_reg <= 16'(({16'b0, fy} * {16'b0, fy}) >> 16);
        fx1_reg <= fx;
        fy1_reg <= fy;
        // stage 2
        sx_reg   <= wx[32:16];
        sy_reg   <= wy[32:16];
        p00x_reg <= dx0 * $signed(c00[15:0]);
        p00y_reg <= dy0 * $signed(c00[31:16]);
        p10x_reg <= dx1 * $signed(c10[15:0]);
        p10y_reg <= dy0 * $signed(c10[31:16]);
        p01x_reg <= dx0 * $signed(c01[15:0]);
        p01y_reg <= dy1 * $signed(c01[31:16]);
        p11x_reg <= dx1 * $signed(c11[15:0]);
        p11y_reg <= dy1 * $signed(c11[31:16]);
        // stage 3
        n00_reg <= 34'(p00x_reg) + 34'(p00y_reg);
        n10_reg <= 34'(p10x_reg) + 34'(p10y_reg);
        n01_reg <= 34'(p01x_reg) + 34'(p01y_reg);
        n11_reg <= 34'(p11x_reg) + 34'(p11y_reg);
        sx2_reg <= sx_reg;
        sy2_reg <= sy_reg;
        // stage 4
        dt_reg    <= 35'(n10_reg) - 35'(n00_reg);
        db_reg    <= 35'(n11_reg) - 35'(n01_reg);
        n00_4_reg <= n00_reg;
        n01_4_reg <= n01_reg;
        sx3_reg   <= sx2_reg;
        sy3_reg   <= sy2_reg;
        // stage 5
        pt_reg    <= dt_reg * $signed({1'b0, sx3_reg});
        pb_reg    <= db_reg * $signed({1'b0, sx3_reg});
        n00_5_reg <= n00_4_reg;
        n01_5_reg <= n01_4_reg;
        sy4_reg   <= sy3_reg;
        // stage 6: floor shift of the blend term
        top_reg <= 36'(n00_5_reg) + 36'(pt_reg >>> 16);
        bot_reg <= 36'(n01_5_reg) + 36'(pb_reg >>> 16);
        sy5_reg <= sy4_reg;
        // stage 7
        d_reg    <= bot_reg - top_reg;
        top7_reg <= top_reg;
        sy6_reg  <= sy5_reg;
        // stage 8
        p_reg    <= d_reg * $signed({1'b0, sy6_reg});
        top8_reg <= top7_reg;
        // stage 9: Q.30 to Q2.14 with saturation
        if (vq > 20'sd32767)
        begin
            noise_reg <= 16'h7FFF;
        end
        else if (vq < -20'sd32768)
        begin
            noise_reg <= 16'h8000;
        end
        else
        begin
            noise_reg <= vq[15:0];
        end
    end

    assign noise = noise_reg;

endmodule

FILE: hdl/gn2_checker.sv
// Port-level checks for the gradient noise block, bound to the top level.
`timescale 1ns / 1ps
module gn2_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [gn2_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [0:0]                     m_tuser,
    input logic                           psel,
    input logic                           pwrite,
    input logic [gn2_pkg::PDATA_W-1:0]    prdata,
    input logic                           pready
);
    import gn2_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("out-of-range result carries a nonzero value");

    a_rd_width: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && pready |-> prdata[PDATA_W-1:CFG_W] == '0)
        else $error("register read returns bits above the register width");

endmodule

bind gradient_noise_2d gn2_checker u_gn2_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .pwrite   (pwrite),
    .prdata   (prdata),
    .pready   (pready)
);

FILE: tb/sv/tb_gradient_noise_2d.sv
// Self-checking testbench for gradient_noise_2d: directed and random requests with fixed-point prediction.
`timescale 1ns / 1ps
module tb_gradient_noise_2d;
    import gn2_pkg::*;

    localparam int GRID_DIM    = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 24;

    typedef struct {
        logic signed [15:0] noise;
        logic               oor;
    } noise_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    gradient_noise_2d i_dut (.*);

    always #1 clk = ~clk;

    // predictor state
    logic signed [15:0] grad_x_mem [GRID_DIM*GRID_DIM];
    logic signed [15:0] grad_y_mem [GRID_DIM*GRID_DIM];
    bit                 grad_written [GRID_DIM*GRID_DIM];
    logic [6:0]         cfg_width = 7'd2;
    logic [6:0]         cfg_height = 7'd2;
    logic [6:0]         cfg_scale = 7'd1;
    noise_res_t         noise_q [$];

    int  mismatches = 0;
    int  cycles = 0;
    bit  no_gaps = 0;
    bit  no_stalls = 0;
    int  stall_left = 0;

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int eff_width();
        return clampi(int'(cfg_width), 2, GRID_DIM);
    endfunction

    function automatic int eff_height();
        return clampi(int'(cfg_height), 2, GRID_DIM);
    endfunction

    function automatic int eff_scale();
        return clampi(int'(cfg_scale), 1, GRID_DIM);
    endfunction

    function automatic longint smooth_weight(longint f);
        longint unsigned uf, f2, t;
        uf = f;
        f2 = (uf * uf) >> 16;
        t = 64'd196608 - 2 * uf;
        return longint'((f2 * t) >> 16);
    endfunction

    function automatic longint corner_dot(int col, int row, longint dx, longint dy);
        int idx;
        idx = row * GRID_DIM + col;
        return dx * longint'(grad_x_mem[idx]) + dy * longint'(grad_y_mem[idx]);
    endfunction

    function automatic longint lerp_q30(longint a0, longint a1, longint s);
        return a0 + (((a1 - a0) * s) >>> 16);
    endfunction

    function automatic noise_res_t predict_noise(int px, int py);
        noise_res_t r;
        int sf, x0, y0;
        longint fx, fy, sx, sy, top, bot, v;
        sf = eff_scale();
        r.noise = '0;
        r.oor = 1'b1;
        if (px >= (eff_width() - 1) * sf || py >= (eff_height() - 1) * sf)
            return r;
        x0 = px / sf;
        y0 = py / sf;
        fx = (longint'(px % sf) << 16) / sf;
        fy = (longint'(py % sf) << 16) / sf;
        sx = smooth_weight(fx);
        sy = smooth_weight(fy);
        top = lerp_q30(corner_dot(x0, y0, fx, fy), corner_dot(x0 + 1, y0, fx - 65536, fy), sx);
        bot = lerp_q30(corner_dot(x0, y0 + 1, fx, fy - 65536),
                       corner_dot(x0 + 1, y0 + 1, fx - 65536, fy - 65536), sx);
        v = lerp_q30(top, bot, sy) >>> 16;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        r.noise = v[15:0];
        r.oor = 1'b0;
        return r;
    endfunction

    // all four corners must hold written gradients before an in-range evaluate
    function automatic bit corners_known(int px, int py);
        int sf, x0, y0;
        sf = eff_scale();
        if (px >= (eff_width() - 1) * sf || py >= (eff_height() - 1) * sf)
            return 1'b1;
        x0 = px / sf;
        y0 = py / sf;
        return grad_written[y0*GRID_DIM+x0] && grad_written[y0*GRID_DIM+x0+1]
            && grad_written[(y0+1)*GRID_DIM+x0] && grad_written[(y0+1)*GRID_DIM+x0+1];
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** gradient_noise_2d: FAILED **");
            $finish;
        end
    end

    // result sink with random back-pressure
    always @(posedge clk)
    begin
        if (no_stalls || stall_left == 0)
        begin
            m_tready <= 1'b1;
            if (!no_stalls && $urandom_range(0, 99) < 15)
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
        end
        else
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge clk)
    begin
        noise_res_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (noise_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: noise=%0d oor=%0d",
                             $signed(m_tdata), m_tuser[0]);
            end
            else
            begin
                exp_r = noise_q.pop_front();
                if (m_tdata !== exp_r.noise || m_tuser[0] !== exp_r.oor)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp noise=%0d oor=%0d, got noise=%0d oor=%0d",
                                 exp_r.noise, exp_r.oor, $signed(m_tdata), m_tuser[0]);
                end
            end
        end
    end

    task automatic idle_gap();
        int r, n;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return;
        n = (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_request(logic op, int col, int row, int gx, int gy, int px, int py);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[5:0] = 6'(col);
        d[11:6] = 6'(row);
        d[27:12] = 16'(gx);
        d[43:28] = 16'(gy);
        d[55:44] = 12'(px);
        d[67:56] = 12'(py);
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == OP_WRITE)
        begin
            grad_x_mem[d[11:6]*GRID_DIM+d[5:0]] = d[27:12];
            grad_y_mem[d[11:6]*GRID_DIM+d[5:0]] = d[43:28];
            grad_written[d[11:6]*GRID_DIM+d[5:0]] = 1'b1;
        end
        else
            noise_q.push_back(predict_noise(int'(d[55:44]), int'(d[67:56])));
        idle_gap();
    endtask

    task automatic write_gradient(int col, int row, int gx, int gy);
        send_request(OP_WRITE, col, row, gx, gy, $urandom_range(0, 4095),
                     $urandom_range(0, 4095));
    endtask

    task automatic eval_pixel(int px, int py);
        send_request(OP_EVAL, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 65535), $urandom_range(0, 65535), px, py);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (noise_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [6:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:  cfg_width = value;
            REG_GRID_HEIGHT: cfg_height = value;
            default:         cfg_scale = value;
        endcase
    endtask

    task automatic set_grid(logic [6:0] w, logic [6:0] h, logic [6:0] sf);
        wait_idle();
        apb_write(REG_GRID_WIDTH, w);
        apb_write(REG_GRID_HEIGHT, h);
        apb_write(REG_SCALE, sf);
    endtask

    function automatic int rand_grad();
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    // reset settings: a single pixel layer, the four corners written with gradients of +/-16384 or 0
    task automatic test_reset_layer();
        write_gradient(0, 0, 16384, -16384);
        write_gradient(1, 0, -16384, 16384);
        write_gradient(0, 1, 0, 16384);
        write_gradient(1, 1, -16384, -16384);
        eval_pixel(0, 0);
        eval_pixel(1, 0);
        eval_pixel(0, 1);
        eval_pixel(4095, 4095);
    endtask

    task automatic test_directed_blend();
        set_grid(7'd3, 7'd3, 7'd4);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                write_gradient(c, r, (c + r) % 2 ? 16384 : -16384, (c == 1) ? 0 : 16384);
        eval_pixel(1, 1);
        eval_pixel(3, 3);
        eval_pixel(5, 2);
        eval_pixel(7, 7);
        eval_pixel(8, 0);
        eval_pixel(0, 8);
        // write to the far corner of the store, then sample it at full grid
        set_grid(7'd64, 7'd64, 7'd64);
        write_gradient(62, 62, 16384, 16384);
        write_gradient(63, 62, -16384, 16384);
        write_gradient(62, 63, 16384, -16384);
        write_gradient(63, 63, -16384, -16384);
        eval_pixel(4031, 4031);
        eval_pixel(62 * 64 + 32, 62 * 64 + 1);
        eval_pixel(4032, 0);
    endtask

    task automatic run_random_phase(logic [6:0] w, logic [6:0] h, logic [6:0] sf, int n_items);
        int gw, gh, s, bx, by, bw, bh, r, px, py;
        set_grid(w, h, sf);
        gw = eff_width();
        gh = eff_height();
        s = eff_scale();
        bx = $urandom_range(0, gw - 2);
        by = $urandom_range(0, gh - 2);
        bw = clampi(gw - bx, 2, 6);
        bh = clampi(gh - by, 2, 6);
        for (int yy = 0; yy < bh; yy++)
            for (int xx = 0; xx < bw; xx++)
                write_gradient(bx + xx, by + yy, rand_grad(), rand_grad());
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                px = (bx + $urandom_range(0, bw - 2)) * s + $urandom_range(0, s - 1);
                py = (by + $urandom_range(0, bh - 2)) * s + $urandom_range(0, s - 1);
                eval_pixel(px, py);
            end
            else if (r < 75)
                write_gradient(bx + $urandom_range(0, bw - 1), by + $urandom_range(0, bh - 1),
                               rand_grad(), rand_grad());
            else if (r < 90)
            begin
                px = $urandom_range(0, 4095);
                py = $urandom_range(0, 4095);
                if (!corners_known(px, py))
                    px = 4095;
                eval_pixel(px, py);
            end
            else
                write_gradient($urandom_range(0, 63), $urandom_range(0, 63),
                               rand_grad(), rand_grad());
        end
    endtask

    task automatic test_random_grids();
        run_random_phase(7'd2, 7'd2, 7'd1, 80);
        run_random_phase(7'd64, 7'd64, 7'd64, 150);
        run_random_phase(7'd0, 7'd127, 7'd0, 80);
        run_random_phase(7'd127, 7'd2, 7'd127, 80);
        no_gaps = 1;
        no_stalls = 1;
        run_random_phase(7'd9, 7'd9, 7'd3, 150);
        no_stalls = 0;
        run_random_phase(7'd5, 7'd4, 7'd7, 120);
        no_gaps = 0;
        run_random_phase(7'd64, 7'd64, 7'd1, 120);
        run_random_phase(7'd17, 7'd33, 7'd13, 150);
        run_random_phase(7'd3, 7'd64, 7'd37, 120);
        run_random_phase(7'd40, 7'd12, 7'd64, 120);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_reset_layer();
        test_directed_blend();
        test_random_grids();
        wait_idle();
        if (mismatches == 0)
            $display("** gradient_noise_2d: PASSED **");
        else
            $display("** gradient_noise_2d: FAILED **");
        $finish;
    end

endmodule
